// ----- rtl/highpass_tanh_soft_limiter_macros.svh -----
// Assertion macros shared by the limiter RTL.
// Both expect a clock named clk in scope; HTSL_ASSERT also expects an active-low reset named rst_n.
`ifndef HIGHPASS_TANH_SOFT_LIMITER_MACROS_SVH
`define HIGHPASS_TANH_SOFT_LIMITER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HTSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define HTSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/htsl_pkg.sv -----
`default_nettype none

package htsl_pkg;

  // Field and register widths.
  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 16;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 2'd1;

  // Reset values of the registers.
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd63540;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd16;

  // Filter state widths: the filtered value is signed Q3.31.
  localparam int FILT_W = 34;

  // Table size; it must be a power of two in the range 32 to 4096.
  localparam int TANH_TABLE_ENTRIES = 256;
  localparam int IDX_W  = $clog2(TANH_TABLE_ENTRIES);
  localparam int FRAC_W = FILT_W - IDX_W;

  // Largest output magnitude.
  localparam logic [OUT_W-1:0] OUT_MAX = 16'd32767;

  // Digit-serial multiplier: signed multiplicand, unsigned multiplier taken
  // one digit per cycle, least significant digit first.
  localparam int MUL_DIGIT   = 4;
  localparam int MC_W        = 36;
  localparam int COEF_STEPS  = (COEF_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int GAIN_STEPS  = (GAIN_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int FRAC_STEPS  = FRAC_W / MUL_DIGIT + 1;
  localparam int MP_W        = FRAC_STEPS * MUL_DIGIT;
  localparam int MUL_CNT_W   = $clog2(FRAC_STEPS + 1);

  // Multiplier request from the sequencer.
  typedef struct packed {
    logic                   start;
    logic [MUL_CNT_W-1:0]   steps;
    logic signed [MC_W-1:0] mcand;
    logic [MP_W-1:0]        mplier;
  } mul_ctl_t;

  // Multiplier status: the product is {acc_hi, top bits of acc_lo}.
  typedef struct packed {
    logic                   done;
    logic signed [MC_W-1:0] acc_hi;
    logic [MP_W-1:0]        acc_lo;
  } mul_sts_t;

  // Table lookup result: lower entry and distance to the next one.
  typedef struct packed {
    logic [OUT_W-1:0] lo;
    logic [OUT_W-1:0] diff;
  } lut_out_t;

  typedef logic [OUT_W-1:0] tanh_tab_t [TANH_TABLE_ENTRIES];

  localparam logic [63:0] ONE_Q32  = 64'h1_0000_0000;
  localparam logic [63:0] TAYLOR_X = (64'd16 << 32) / TANH_TABLE_ENTRIES;

  // Long division used only while the table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds tanh(8k/N) in Q1.15, built from exp(-16/N) in Q0.32.
  function automatic tanh_tab_t build_tanh_table();
    tanh_tab_t   tab;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] v;
    term = ONE_Q32;
    r    = ONE_Q32;
    e    = ONE_Q32;
    for (int i = 1; i <= 20; i++) begin
      term = udiv64((term * TAYLOR_X) >> 32, 64'(i));
      if ((i & 1) != 0) r = r - term;
      else              r = r + term;
    end
    for (int k = 0; k < TANH_TABLE_ENTRIES; k++) begin
      if (k > 0) e = (e * r + 64'h8000_0000) >> 32;
      num = (ONE_Q32 - e) << 16;
      den = (ONE_Q32 + e) << 1;
      v   = udiv64((num << 1) + den, den << 1);
      if (v > 64'd32767) v = 64'd32767;
      tab[k] = v[OUT_W-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TABLE = build_tanh_table();

endpackage

`default_nettype wire

// ----- rtl/htsl_serial_mult.sv -----
`default_nettype none

module htsl_serial_mult
  import htsl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mul_ctl_t ctl,
  output mul_sts_t  sts
);

  logic signed [MC_W-1:0] a_r;
  logic [MP_W-1:0]        m_r;
  logic signed [MC_W-1:0] s_r;
  logic [MP_W-1:0]        l_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic                   busy_r;

  logic signed [MC_W+MUL_DIGIT:0] part;
  logic signed [MC_W+MUL_DIGIT:0] acc;

  // One digit of the multiplier times the multiplicand, added to the high part.
  always_comb begin
    part = a_r * $signed({1'b0, m_r[MUL_DIGIT-1:0]});
    acc  = {{(MUL_DIGIT+1){s_r[MC_W-1]}}, s_r} + part;
  end

  // Control state of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctl.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  // The low digit of each partial sum shifts into the low word.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= ctl.mcand;
      m_r <= ctl.mplier;
      s_r <= '0;
      l_r <= '0;
    end else if (busy_r) begin
      m_r <= {{MUL_DIGIT{1'b0}}, m_r[MP_W-1:MUL_DIGIT]};
      s_r <= acc[MC_W+MUL_DIGIT-1:MUL_DIGIT];
      l_r <= {acc[MUL_DIGIT-1:0], l_r[MP_W-1:MUL_DIGIT]};
    end
  end

  assign sts.done   = !busy_r;
  assign sts.acc_hi = s_r;
  assign sts.acc_lo = l_r;

endmodule

`default_nettype wire

// ----- rtl/htsl_tanh_lut.sv -----
`default_nettype none

module htsl_tanh_lut
  import htsl_pkg::*;
(
  input  wire logic [IDX_W-1:0] idx,
  output lut_out_t              lut
);

  logic [OUT_W-1:0] lo;
  logic [OUT_W-1:0] hi;

  // Neighbouring entries; past the last entry the curve is taken as full scale.
  always_comb begin
    lo = TANH_TABLE[idx];
    if (idx == IDX_W'(TANH_TABLE_ENTRIES - 1)) hi = OUT_MAX;
    else                                       hi = TANH_TABLE[idx + IDX_W'(1)];
    if (hi < lo) hi = lo;
    lut.lo   = lo;
    lut.diff = hi - lo;
  end

endmodule

`default_nettype wire

// ----- rtl/highpass_tanh_soft_limiter.sv -----
// One-pole high-pass filter followed by a tanh soft limiter.
// Input channel: in_valid/in_ready carry one signed Q1.31 sample per word on
// in_input_sample. Output channel: out_valid/out_ready carry one signed
// Q1.15 word on out_limited_sample for every input word, in order.
// Configuration: cfg_write_en with cfg_index 0 writes the filter coefficient
// (unsigned Q0.16), index 1 the drive gain (low 7 bits); other indexes are
// ignored. Write only while the block is idle.
// Timing: a word is worked on alone. The three products (coefficient, gain
// and interpolation) go one after another through a shared multiplier that
// takes four bits of its multiplier per cycle; the interpolation product is
// skipped when the drive saturates. in_ready rises again in the cycle in
// which the result is shown.
// Stall: the result waits in the output register while out_ready is low; the
// next word is accepted meanwhile, and its result waits until that register
// is free.
// Reset: rst_n (synchronous) clears the filter history, loads the register
// defaults and empties the output register.
`default_nettype none
`include "highpass_tanh_soft_limiter_macros.svh"

module highpass_tanh_soft_limiter
  import htsl_pkg::*;
(
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  in_valid,
  output logic                        in_ready,
  input  wire  logic signed [SAMPLE_W-1:0] in_input_sample,
  output logic                        out_valid,
  input  wire  logic                  out_ready,
  output logic signed [OUT_W-1:0]     out_limited_sample,
  input  wire  logic                  cfg_write_en,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_LUT,
    S_MUL3,
    S_OUT
  } state_t;

  localparam int Z_W      = MC_W + GAIN_STEPS * MUL_DIGIT;
  localparam int Y_RND    = MP_W - COEF_STEPS * MUL_DIGIT + COEF_W - 1;
  localparam int Q_LOW    = FRAC_STEPS * MUL_DIGIT - FRAC_W;
  localparam int Q_RND    = MP_W - 1 - Q_LOW;

  state_t                    state_r, state_nxt;
  logic [COEF_W-1:0]         coef_r, coef_nxt;
  logic [GAIN_W-1:0]         gain_r, gain_nxt;
  logic signed [SAMPLE_W-1:0] last_in_r, last_in_nxt;
  logic signed [FILT_W-1:0]  last_filt_r, last_filt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_sample_r, out_sample_nxt;
  logic                      neg_r, neg_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [FILT_W-1:0]         mag_r, mag_nxt;
  logic [OUT_W-1:0]          lo_r, lo_nxt;
  logic [OUT_W-1:0]          res_r, res_nxt;

  mul_ctl_t mul_ctl;
  mul_sts_t mul_sts;
  lut_out_t lut;

  logic signed [MC_W-1:0] sum;
  logic signed [MC_W:0]   y_ext;
  logic signed [Z_W-1:0]  z;
  logic [Z_W-1:0]         z_mag;
  logic [OUT_W-1:0]       q;
  logic [OUT_W:0]         v;

  htsl_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .sts   (mul_sts)
  );

  htsl_tanh_lut u_lut (
    .idx (mag_r[FILT_W-1 -: IDX_W]),
    .lut (lut)
  );

  // Datapath values read off the multiplier and the filter history.
  always_comb begin
    sum = {{(MC_W-FILT_W){last_filt_r[FILT_W-1]}}, last_filt_r}
        + {{(MC_W-SAMPLE_W){in_input_sample[SAMPLE_W-1]}}, in_input_sample}
        - {{(MC_W-SAMPLE_W){last_in_r[SAMPLE_W-1]}}, last_in_r};
    // Round to nearest: the bit just below the kept part is added back.
    y_ext = {mul_sts.acc_hi[MC_W-1], mul_sts.acc_hi}
          + {{MC_W{1'b0}}, mul_sts.acc_lo[Y_RND]};
    z     = {mul_sts.acc_hi, mul_sts.acc_lo[MP_W-1 -: GAIN_STEPS*MUL_DIGIT]};
    z_mag = z[Z_W-1] ? (~z + Z_W'(1)) : z;
    q     = {mul_sts.acc_hi[OUT_W-1-Q_LOW:0], mul_sts.acc_lo[MP_W-1 -: Q_LOW]};
    v     = {1'b0, lo_r} + {1'b0, q} + {{OUT_W{1'b0}}, mul_sts.acc_lo[Q_RND]};
  end

  // Sequencer and register next values.
  always_comb begin
    state_nxt      = state_r;
    coef_nxt       = coef_r;
    gain_nxt       = gain_r;
    last_in_nxt    = last_in_r;
    last_filt_nxt  = last_filt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    mag_nxt        = mag_r;
    lo_nxt         = lo_r;
    res_nxt        = res_r;
    mul_ctl.start  = 1'b0;
    mul_ctl.steps  = MUL_CNT_W'(COEF_STEPS);
    mul_ctl.mcand  = sum;
    mul_ctl.mplier = {{(MP_W-COEF_W){1'b0}}, coef_r};
    in_ready       = 1'b0;

    // Register writes.
    if (cfg_write_en && cfg_index == REG_FILTER_COEF) coef_nxt = cfg_data[COEF_W-1:0];
    if (cfg_write_en && cfg_index == REG_DRIVE_GAIN)  gain_nxt = cfg_data[GAIN_W-1:0];

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mul_ctl.start = 1'b1;
          last_in_nxt   = in_input_sample;
          state_nxt     = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_sts.done) begin
          // Saturate the filtered value to the stored width.
          if (y_ext[MC_W:FILT_W-1] == {(MC_W-FILT_W+2){1'b0}} ||
              y_ext[MC_W:FILT_W-1] == {(MC_W-FILT_W+2){1'b1}}) begin
            last_filt_nxt = y_ext[FILT_W-1:0];
          end else if (y_ext[MC_W]) begin
            last_filt_nxt = {1'b1, {(FILT_W-1){1'b0}}};
          end else begin
            last_filt_nxt = {1'b0, {(FILT_W-1){1'b1}}};
          end
          mul_ctl.start  = 1'b1;
          mul_ctl.steps  = MUL_CNT_W'(GAIN_STEPS);
          mul_ctl.mcand  = {{(MC_W-FILT_W){last_filt_nxt[FILT_W-1]}}, last_filt_nxt};
          mul_ctl.mplier = {{(MP_W-GAIN_W){1'b0}}, gain_r};
          state_nxt      = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_sts.done) begin
          neg_nxt   = z[Z_W-1];
          ovf_nxt   = |z_mag[Z_W-1:FILT_W];
          mag_nxt   = z_mag[FILT_W-1:0];
          state_nxt = S_LUT;
        end
      end
      S_LUT: begin
        if (ovf_r) begin
          res_nxt   = OUT_MAX;
          state_nxt = S_OUT;
        end else begin
          // Interpolate between the two neighbouring entries.
          lo_nxt         = lut.lo;
          mul_ctl.start  = 1'b1;
          mul_ctl.steps  = MUL_CNT_W'(FRAC_STEPS);
          mul_ctl.mcand  = {{(MC_W-OUT_W){1'b0}}, lut.diff};
          mul_ctl.mplier = {{(MP_W-FRAC_W){1'b0}}, mag_r[FRAC_W-1:0]};
          state_nxt      = S_MUL3;
        end
      end
      S_MUL3: begin
        if (mul_sts.done) begin
          res_nxt   = (v > {1'b0, OUT_MAX}) ? OUT_MAX : v[OUT_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_sample_nxt = neg_r ? (~res_r + OUT_W'(1)) : res_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, history and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coef_r      <= COEF_RESET;
      gain_r      <= GAIN_RESET;
      last_in_r   <= '0;
      last_filt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coef_r      <= coef_nxt;
      gain_r      <= gain_nxt;
      last_in_r   <= last_in_nxt;
      last_filt_r <= last_filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sample_r <= out_sample_nxt;
    neg_r        <= neg_nxt;
    ovf_r        <= ovf_nxt;
    mag_r        <= mag_nxt;
    lo_r         <= lo_nxt;
    res_r        <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_limited_sample = out_sample_r;

  // Checks on the sequencer and the result range.
  `HTSL_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "word accepted while busy")
  `HTSL_ASSERT(a_mult_free_in_idle, state_r == S_IDLE |-> mul_sts.done, "multiplier busy in idle")
  `HTSL_ASSERT(a_out_in_range, out_valid |-> out_limited_sample != 16'sh8000, "output out of range")

endmodule

`default_nettype wire
